>>> hdl/lrup_pkg.sv
`default_nettype none

package lrup_pkg;

	localparam int FRAMES_DEF    = 8;
	localparam int PAGE_BITS_DEF = 16;

	localparam int PAGE_W      = 16;
	localparam int FRAME_IDX_W = 3;
	localparam int COUNT_W     = 32;
	localparam int CFG_W       = 4;

	localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = CFG_W'(8);

	typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

>>> hdl/lru_page_replacement.sv
`default_nettype none

// channel   handshake                  payload
// in        in_valid / in_stall        page, restart
// out       out_valid / out_stall      fault, frame_index, evicted_valid, evicted_page,
//                                      fault_total
// cfg       cfg_wr_en                  cfg_wr_data (frames_in_use)
//
// One word per cycle while in_stall is low: a word sits in the input register, where the
// frame compare, LRU pick and rank update run, then moves to the result register.
// out_valid rises as the accepted word moves on into the result register.
// arst_n clears frames, ranks, fill count, fault count and sets frames_in_use to 8.
// out_stall holds the result register; in_stall rises only when both registers are full.

module lru_page_replacement #(
	parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [lrup_pkg::CFG_W-1:0]           cfg_wr_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [lrup_pkg::PAGE_W-1:0]          page,
	input  wire logic                                 restart,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic                                      fault,
	output logic [lrup_pkg::FRAME_IDX_W-1:0]          frame_index,
	output logic                                      evicted_valid,
	output logic [lrup_pkg::PAGE_W-1:0]               evicted_page,
	output lrup_pkg::count_t                          fault_total
);

	localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W  = $clog2(FRAMES + 1);
	localparam int IDXO_W  = lrup_pkg::FRAME_IDX_W;
	localparam int PAGEO_W = lrup_pkg::PAGE_W;

	logic [lrup_pkg::CFG_W-1:0] frames_in_use_q;

	logic                 valid_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic                 restart_s1;

	logic [FRAMES-1:0]    frame_valid_q;
	logic [IDX_W-1:0]     rank_q [FRAMES];
	logic [PAGE_BITS-1:0] frame_page_q [FRAMES];
	logic [FILL_W-1:0]    filled_q;
	lrup_pkg::count_t     count_q;

	logic                 out_valid_q;
	logic                 fault_q;
	logic [IDXO_W-1:0]    frame_index_q;
	logic                 evicted_valid_q;
	logic [PAGEO_W-1:0]   evicted_page_q;
	lrup_pkg::count_t     fault_total_q;

	logic                 advance;

	logic [FRAMES-1:0]    vld_e;
	logic [FILL_W-1:0]    filled_e;
	lrup_pkg::count_t     cnt_e;
	logic [FILL_W-1:0]    cap;
	logic                 hit;
	logic [IDX_W-1:0]     hit_idx;
	logic [IDX_W-1:0]     hit_rank;
	logic                 lru_found;
	logic [IDX_W-1:0]     lru_idx;
	logic [IDX_W-1:0]     lru_rank;
	logic                 fill;
	logic [IDX_W-1:0]     f;
	logic                 ev_valid;
	logic [PAGE_BITS-1:0] ev_page;
	logic [FRAMES-1:0]    valid_d;
	logic [IDX_W-1:0]     rank_d [FRAMES];
	logic [FILL_W-1:0]    filled_d;
	lrup_pkg::count_t     cnt_d;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		if (frames_in_use_q == '0) begin
			cap = FILL_W'(1);
		end else if (int'(frames_in_use_q) > FRAMES) begin
			cap = FILL_W'(FRAMES);
		end else begin
			cap = FILL_W'(frames_in_use_q);
		end
	end

	always_comb begin
		vld_e    = restart_s1 ? '0 : frame_valid_q;
		filled_e = restart_s1 ? '0 : filled_q;
		cnt_e    = restart_s1 ? '0 : count_q;

		hit     = 1'b0;
		hit_idx = '0;
		for (int j = FRAMES - 1; j >= 0; j--) begin
			if (vld_e[j] && frame_page_q[j] == page_s1) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(j);
			end
		end
		hit_rank = rank_q[hit_idx];

		lru_rank  = IDX_W'(filled_e - FILL_W'(1));
		lru_found = 1'b0;
		lru_idx   = '0;
		for (int j = FRAMES - 1; j >= 0; j--) begin
			if (vld_e[j] && rank_q[j] == lru_rank) begin
				lru_found = 1'b1;
				lru_idx   = IDX_W'(j);
			end
		end

		fill = !hit && (filled_e < cap);

		if (hit) begin
			f = hit_idx;
		end else if (fill) begin
			f = filled_e[IDX_W-1:0];
		end else if (lru_found) begin
			f = lru_idx;
		end else begin
			f = '0;
		end

		ev_valid = !hit && !fill && lru_found;
		ev_page  = ev_valid ? frame_page_q[lru_idx] : '0;

		valid_d    = vld_e;
		valid_d[f] = 1'b1;

		if (fill) begin
			filled_d = filled_e + FILL_W'(1);
		end else if (!hit && !lru_found) begin
			filled_d = FILL_W'(1);
		end else begin
			filled_d = filled_e;
		end

		for (int j = 0; j < FRAMES; j++) begin
			rank_d[j] = rank_q[j];
			if (vld_e[j] && IDX_W'(j) != f && (!hit || rank_q[j] < hit_rank)) begin
				rank_d[j] = rank_q[j] + IDX_W'(1);
			end
		end
		rank_d[f] = '0;

		cnt_d = (!hit && cnt_e != '1) ? cnt_e + lrup_pkg::COUNT_W'(1) : cnt_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= lrup_pkg::FRAMES_IN_USE_RST;
			valid_s1        <= 1'b0;
			out_valid_q     <= 1'b0;
			frame_valid_q   <= '0;
			filled_q        <= '0;
			count_q         <= '0;
			for (int j = 0; j < FRAMES; j++) begin
				rank_q[j] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				frames_in_use_q <= cfg_wr_data;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q   <= 1'b1;
				frame_valid_q <= valid_d;
				filled_q      <= filled_d;
				count_q       <= cnt_d;
				for (int j = 0; j < FRAMES; j++) begin
					rank_q[j] <= rank_d[j];
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			page_s1    <= PAGE_BITS'(page);
			restart_s1 <= restart;
		end
		if (advance) begin
			if (!hit) begin
				frame_page_q[f] <= page_s1;
			end
			fault_q         <= !hit;
			frame_index_q   <= IDXO_W'(f);
			evicted_valid_q <= ev_valid;
			evicted_page_q  <= PAGEO_W'(ev_page);
			fault_total_q   <= cnt_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign fault         = fault_q;
	assign frame_index   = frame_index_q;
	assign evicted_valid = evicted_valid_q;
	assign evicted_page  = evicted_page_q;
	assign fault_total   = fault_total_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;

	typedef struct packed {
		logic                             flt;
		logic [lrup_pkg::FRAME_IDX_W-1:0] idx;
		logic                             ev_v;
		logic [lrup_pkg::PAGE_W-1:0]      ev_pg;
		lrup_pkg::count_t                 total;
	} lookup_t;

	typedef struct {
		int                          cap;
		logic [lrup_pkg::PAGE_W-1:0] pg;
		logic                        rs;
		bit                          typed;
		lookup_t                     want;
	} dir_row_t;

	localparam int NFRAMES  = lrup_pkg::FRAMES_DEF;
	localparam int DIR_ROWS = 20;
	localparam int PHASES   = 6;
	localparam int PHASE_WORDS = 158;

	logic                             clk;
	logic                             arst_n      = 1'b0;
	logic                             cfg_wr_en   = 1'b0;
	logic [lrup_pkg::CFG_W-1:0]       cfg_wr_data = '0;
	logic                             in_valid    = 1'b0;
	logic                             in_stall;
	logic [lrup_pkg::PAGE_W-1:0]      page        = '0;
	logic                             restart     = 1'b0;
	logic                             out_valid;
	logic                             out_stall   = 1'b0;
	logic                             fault;
	logic [lrup_pkg::FRAME_IDX_W-1:0] frame_index;
	logic                             evicted_valid;
	logic [lrup_pkg::PAGE_W-1:0]      evicted_page;
	lrup_pkg::count_t                 fault_total;

	lookup_t expected_lookups[$];
	int      mismatches = 0;
	int      words_in   = 0;
	bit      quiet      = 1'b0;
	int      hold_left  = 0;
	bit      hold_done  = 1'b0;

	// predictor state
	logic [lrup_pkg::PAGE_W-1:0] fr_page  [NFRAMES] = '{default: '0};
	bit                          fr_valid [NFRAMES] = '{default: 1'b0};
	int                          fr_rank  [NFRAMES] = '{default: 0};
	int                          fr_filled = 0;
	lrup_pkg::count_t            fr_faults = '0;
	logic [lrup_pkg::CFG_W-1:0]  cap_reg   = lrup_pkg::FRAMES_IN_USE_RST;

	dir_row_t dir_tab [DIR_ROWS];

	lru_page_replacement u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.page         (page),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.fault        (fault),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.fault_total  (fault_total)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("lru_page_replacement: mismatch");
		$finish;
	end

	function automatic lookup_t lru_lookup(input logic [lrup_pkg::PAGE_W-1:0] pg,
			input logic rs);
		lookup_t r;
		int      cap;
		int      tgt;
		int      limit;
		int      best;
		bit      found;
		r = '0;
		tgt = -1;
		if (rs) begin
			for (int j = 0; j < NFRAMES; j++) begin
				fr_page[j] = '0;
				fr_valid[j] = 1'b0;
				fr_rank[j] = 0;
			end
			fr_filled = 0;
			fr_faults = '0;
		end
		for (int j = 0; j < NFRAMES; j++)
			if (tgt < 0 && fr_valid[j] && fr_page[j] == pg)
				tgt = j;
		cap = (cap_reg < 1) ? 1 : ((cap_reg > NFRAMES) ? NFRAMES : int'(cap_reg));
		if (tgt >= 0) begin
			limit = fr_rank[tgt];
		end else begin
			r.flt = 1'b1;
			limit = NFRAMES + 1;
			if (fr_filled < cap) begin
				tgt = fr_filled;
				fr_valid[tgt] = 1'b1;
				fr_filled++;
			end else begin
				found = 1'b0;
				best = 0;
				tgt = 0;
				for (int j = 0; j < NFRAMES; j++) begin
					if (fr_valid[j] && (!found || fr_rank[j] > best)) begin
						best = fr_rank[j];
						tgt = j;
						found = 1'b1;
					end
				end
				if (found) begin
					r.ev_v = 1'b1;
					r.ev_pg = fr_page[tgt];
				end else begin
					fr_valid[0] = 1'b1;
					fr_filled = 1;
				end
			end
			fr_page[tgt] = pg;
			if (fr_faults != '1)
				fr_faults++;
		end
		// age every valid frame newer than the target (all of them on a fault), then make the target newest
		for (int j = 0; j < NFRAMES; j++)
			if (j != tgt && fr_valid[j] && fr_rank[j] < limit)
				fr_rank[j]++;
		fr_rank[tgt] = 0;
		r.idx = tgt[lrup_pkg::FRAME_IDX_W-1:0];
		r.total = fr_faults;
		return r;
	endfunction

	task automatic put_word(input logic [lrup_pkg::PAGE_W-1:0] pg, input logic rs,
			input bit typed, input lookup_t want);
		lookup_t got;
		while (!quiet && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		page <= pg;
		restart <= rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = lru_lookup(pg, rs);
		expected_lookups.insert(expected_lookups.size(), typed ? want : got);
		words_in++;
	endtask

	task automatic set_cap(input logic [lrup_pkg::CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cap_reg = v;
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : chk_out
		lookup_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lookups.size() == 0) begin
				$display("%0t: unexpected word, expected none got page frame %0d total %0h",
					$time, frame_index, fault_total);
				mismatches++;
			end else begin
				want = expected_lookups.pop_front();
				check_field("fault", 32'(want.flt), 32'(fault));
				check_field("frame_index", 32'(want.idx), 32'(frame_index));
				check_field("evicted_valid", 32'(want.ev_v), 32'(evicted_valid));
				check_field("evicted_page", 32'(want.ev_pg), 32'(evicted_page));
				check_field("fault_total", want.total, fault_total);
			end
		end
	end

	// receiver: random stalls, one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && words_in >= 400) begin
			hold_done <= 1'b1;
			hold_left <= 80;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < 17);
		end
	end

	initial begin : main
		logic [lrup_pkg::PAGE_W-1:0] pool [16];
		logic [lrup_pkg::CFG_W-1:0]  caps [PHASES];
		int                          ws;
		int                          r;
		logic                        rs;
		logic [lrup_pkg::PAGE_W-1:0] pg;

		dir_tab = '{
			'{-1, 16'h0000, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1}},
			'{-1, 16'hFFFF, 1'b0, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 32'd2}},
			'{-1, 16'h0000, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd2}},
			'{-1, 16'h0001, 1'b0, 1'b1, '{1'b1, 3'd2, 1'b0, 16'h0000, 32'd3}},
			'{-1, 16'h0002, 1'b0, 1'b0, '0},
			'{-1, 16'h0003, 1'b0, 1'b0, '0},
			'{-1, 16'h0004, 1'b0, 1'b0, '0},
			'{-1, 16'h0005, 1'b0, 1'b0, '0},
			'{-1, 16'h0006, 1'b0, 1'b0, '0},
			'{-1, 16'h0007, 1'b0, 1'b1, '{1'b1, 3'd1, 1'b1, 16'hFFFF, 32'd9}},
			'{ 2, 16'h0005, 1'b0, 1'b0, '0},
			'{-1, 16'h0009, 1'b0, 1'b0, '0},
			'{-1, 16'h1234, 1'b1, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1}},
			'{ 0, 16'h5555, 1'b1, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1}},
			'{-1, 16'hAAAA, 1'b0, 1'b1, '{1'b1, 3'd0, 1'b1, 16'h5555, 32'd2}},
			'{-1, 16'hAAAA, 1'b0, 1'b1, '{1'b0, 3'd0, 1'b0, 16'h0000, 32'd2}},
			'{15, 16'h0F0F, 1'b0, 1'b1, '{1'b1, 3'd1, 1'b0, 16'h0000, 32'd3}},
			'{-1, 16'hF0F0, 1'b0, 1'b1, '{1'b1, 3'd2, 1'b0, 16'h0000, 32'd4}},
			'{-1, 16'h0F0F, 1'b0, 1'b0, '0},
			'{-1, 16'hAAAA, 1'b1, 1'b1, '{1'b1, 3'd0, 1'b0, 16'h0000, 32'd1}}
		};
		caps = '{4'd3, 4'd8, 4'd1, 4'd6, 4'd0, 4'd15};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_tab[i].cap >= 0)
				set_cap(lrup_pkg::CFG_W'(dir_tab[i].cap));
			put_word(dir_tab[i].pg, dir_tab[i].rs, dir_tab[i].typed, dir_tab[i].want);
		end

		for (int p = 0; p < PHASES; p++) begin
			set_cap(p == PHASES - 1 ? lrup_pkg::CFG_W'($urandom_range(15)) : caps[p]);
			for (int k = 0; k < 16; k++)
				pool[k] = lrup_pkg::PAGE_W'($urandom);
			ws = $urandom_range(12, 2);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				quiet = (p == 3 && n < 100);
				r = $urandom_range(99);
				rs = (r < 3);
				if ($urandom_range(99) < 88)
					pg = pool[$urandom_range(ws - 1)];
				else
					pg = lrup_pkg::PAGE_W'($urandom);
				put_word(pg, rs, 1'b0, '0);
			end
		end
		quiet = 1'b0;

		in_valid <= 1'b0;
		while (expected_lookups.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatches == 0 && expected_lookups.size() == 0)
			$display("lru_page_replacement: match");
		else
			$display("lru_page_replacement: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
